// ----- rtl/hkcs_pkg.sv -----
package hkcs_pkg;

  localparam int KEY_W  = 64;
  localparam int DCNT_W = 11;
  localparam int OVF_W  = 32;
  localparam int ADDR_W = 16;

  localparam logic [63:0] MIX_C1 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_C2 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C3 = 64'h94D049BB133111EB;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_PRESENT  = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;
  localparam logic [1:0] ST_CLEARED  = 2'd3;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DCNT_W-1:0] distinct_count;
    logic [OVF_W-1:0]  overflow_count;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_used;
    logic              wr_key_en;
    logic [KEY_W-1:0]  wr_key;
  } tbl_req_t;

endpackage

// ----- rtl/hkcs_hash.sv -----
module hkcs_hash import hkcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output logic [KEY_W-1:0] hash
);

  logic        busy;
  logic        rnd;
  logic [1:0]  step;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] mul_b;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] pre_sum;
  logic [63:0] acc_fin;
  logic [63:0] mixed;

  assign pre_sum = key + MIX_C1;
  assign mul_b   = rnd ? MIX_C3 : MIX_C2;
  assign acc_fin = acc + {prod[31:0], 32'h0};
  assign mixed   = rnd ? (acc_fin ^ (acc_fin >> 31)) : (acc_fin ^ (acc_fin >> 27));

  always_comb begin
    unique case (step)
      2'd0: begin
        ma = hash[31:0];
        mb = mul_b[31:0];
      end
      2'd1: begin
        ma = hash[31:0];
        mb = mul_b[63:32];
      end
      default: begin
        ma = hash[63:32];
        mb = mul_b[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        hash <= pre_sum ^ (pre_sum >> 30);
        busy <= 1'b1;
        rnd  <= 1'b0;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        unique case (step)
          2'd0: prod <= ma * mb;
          2'd1: begin
            prod <= ma * mb;
            acc  <= prod;
          end
          2'd2: begin
            prod <= ma * mb;
            acc  <= acc_fin;
          end
          default: begin
            hash <= mixed;
            if (rnd) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              rnd <= 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/hkcs_table.sv -----
module hkcs_table import hkcs_pkg::*; #(
  parameter int TABLE_SIZE = 1024,
  parameter int IW         = 10
) (
  input  logic             clk,
  input  tbl_req_t         req,
  output logic             rd_used,
  output logic [KEY_W-1:0] rd_key
);

  logic             used_mem [TABLE_SIZE];
  logic [KEY_W-1:0] key_mem  [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      used_mem[req.wr_addr[IW-1:0]] <= req.wr_used;
    end
    rd_used <= used_mem[req.rd_addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && req.wr_key_en) begin
      key_mem[req.wr_addr[IW-1:0]] <= req.wr_key;
    end
    rd_key <= key_mem[req.rd_addr[IW-1:0]];
  end

endmodule

// ----- rtl/hashed_key_census_set_core.sv -----
// flow: an add is hashed on the shared 32x32 multiplier, then reads the table once per probed
// slot, and its result goes to the output register; a clear sweeps every table slot before
// its result is given
// throughput: one word at a time; the input stalls until the result of an add or a clear is
// registered, and longer while a finished result is stalled
// reset: synchronous, active high; clears counters, then sweeps the table with the input stalled
module hashed_key_census_set_core import hkcs_pkg::*; #(
  parameter int TABLE_SIZE  = 1024,
  parameter int PROBE_LIMIT = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int PW = $clog2(PROBE_LIMIT + 1);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam logic [IW-1:0] MASK = IW'(TABLE_SIZE - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t           state;
  logic [IW-1:0]    clr_idx;
  logic             clr_emit;
  logic [KEY_W-1:0] key_reg;
  logic [CW-1:0]    stored_count;
  logic [OVF_W-1:0] dropped_count;
  logic [1:0]       res_status;
  logic [IW-1:0]    home_addr;
  logic [IW-1:0]    probe_addr;
  logic [PW-1:0]    iss_cnt;
  logic [IW-1:0]    ev_addr;
  logic [PW-1:0]    ev_cnt;
  logic             rd_vld;
  logic             issue;
  logic             hash_start;
  logic             hash_done;
  logic [KEY_W-1:0] hash;
  logic             rd_used;
  logic [KEY_W-1:0] rd_key;
  logic             do_insert;
  tbl_req_t         req;

  assign item_stall = (state != S_IDLE);
  assign hash_start = (state == S_IDLE) && item_valid && (item.mode == MODE_ADD);
  assign issue      = (state == S_PROBE) && (iss_cnt < PW'(PROBE_LIMIT));
  assign do_insert  = (state == S_PROBE) && rd_vld && !rd_used;
  assign probe_addr = (home_addr + IW'(iss_cnt)) & MASK;

  always_comb begin
    req.rd_addr   = ADDR_W'(probe_addr);
    req.wr_en     = (state == S_CLEAR) || do_insert;
    req.wr_addr   = (state == S_CLEAR) ? ADDR_W'(clr_idx) : ADDR_W'(ev_addr);
    req.wr_used   = (state != S_CLEAR);
    req.wr_key_en = do_insert;
    req.wr_key    = key_reg;
  end

  hkcs_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (item.key),
    .done  (hash_done),
    .hash  (hash)
  );

  hkcs_table #(
    .TABLE_SIZE (TABLE_SIZE),
    .IW         (IW)
  ) u_table (
    .clk     (clk),
    .req     (req),
    .rd_used (rd_used),
    .rd_key  (rd_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      clr_emit      <= 1'b0;
      stored_count  <= '0;
      dropped_count <= '0;
      rd_vld        <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_EMIT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == MASK) begin
            state <= clr_emit ? S_EMIT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            if (item.mode == MODE_CLEAR) begin
              state         <= S_CLEAR;
              clr_idx       <= '0;
              clr_emit      <= 1'b1;
              stored_count  <= '0;
              dropped_count <= '0;
              res_status    <= ST_CLEARED;
            end else begin
              key_reg <= item.key;
              state   <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            home_addr <= hash[IW-1:0] & MASK;
            iss_cnt   <= '0;
            ev_cnt    <= '0;
            rd_vld    <= 1'b0;
            state     <= S_PROBE;
          end
        end
        S_PROBE: begin
          rd_vld <= issue;
          if (issue) begin
            iss_cnt <= iss_cnt + PW'(1);
            ev_addr <= probe_addr;
          end
          if (rd_vld) begin
            priority if (!rd_used) begin
              stored_count <= stored_count + CW'(1);
              res_status   <= ST_INSERTED;
              state        <= S_EMIT;
            end else if (rd_key == key_reg) begin
              res_status <= ST_PRESENT;
              state      <= S_EMIT;
            end else if (ev_cnt == PW'(PROBE_LIMIT - 1)) begin
              dropped_count <= dropped_count + OVF_W'(1);
              res_status    <= ST_DROPPED;
              state         <= S_EMIT;
            end else begin
              ev_cnt <= ev_cnt + PW'(1);
            end
          end
        end
        S_EMIT: begin
          if (!result_valid || !result_stall) begin
            result_valid          <= 1'b1;
            result.status         <= res_status;
            result.distinct_count <= DCNT_W'(stored_count);
            result.overflow_count <= dropped_count;
            clr_emit              <= 1'b0;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // no word taken while the sweep runs
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> item_stall)
    else $error("item taken during table sweep");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CW'(TABLE_SIZE))
    else $error("distinct count above table size");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> (stored_count == $past(stored_count) + CW'(1)))
    else $error("insert without count update");

  a_probe_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (ev_cnt < PW'(PROBE_LIMIT)))
    else $error("probe beyond limit");

  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && (!result_valid || !result_stall)) |=> (state == S_IDLE))
    else $error("result emitted without returning to idle");

endmodule
